/* hw/rtl/pcp_pkg.sv */
// shared types and constants of the pwm command parser
`timescale 1ns / 1ps
`default_nettype none

package pcp_pkg;

   localparam int CHAR_W    = 8;
   localparam int VALUE_W   = 16;
   localparam int POS_W     = 4;
   localparam int DIGIT_W   = 4;
   localparam int FREQ_W    = 7;
   localparam int DUTY_W    = 7;
   localparam int DIV_W     = VALUE_W + DUTY_W;
   localparam int STEP_W    = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   localparam logic [POS_W-1:0] POS_FIRST      = 4'd1;
   localparam logic [POS_W-1:0] POS_INT        = 4'd1;
   localparam logic [POS_W-1:0] POS_TENTHS     = 4'd3;
   localparam logic [POS_W-1:0] POS_DUTY_TENS  = 4'd9;
   localparam logic [POS_W-1:0] POS_DUTY_UNITS = 4'd10;
   localparam logic [POS_W-1:0] POS_LAST       = 4'd12;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_NUM    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_SCALE = 1'd1;

   localparam logic [VALUE_W-1:0] PERIOD_NUM_RESET    = 16'd40000;
   localparam logic [VALUE_W-1:0] COMPARE_SCALE_RESET = 16'd400;
   localparam logic [VALUE_W-1:0] VALUE_MAX           = 16'hFFFF;

   localparam logic [STEP_W-1:0] STEPS_TOP     = STEP_W'(VALUE_W);
   localparam logic [STEP_W-1:0] STEPS_COMPARE = STEP_W'(DIV_W);

   // frame summary from the parser for the character currently offered
   typedef struct packed {
      logic              last;
      logic              digit_error;
      logic [FREQ_W-1:0] freq;
      logic [DUTY_W-1:0] duty;
   } frame_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [FREQ_W-1:0]  divisor;
      logic [STEP_W-1:0]  steps;
   } div_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_status_type;

endpackage

`default_nettype wire

/* hw/rtl/pcp_if.sv */
// valid/ready channels for characters in and timer settings out
`timescale 1ns / 1ps
`default_nettype none

interface pcp_req_if;
   logic                       valid;
   logic                       ready;
   logic [pcp_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface pcp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pcp_pkg::VALUE_W-1:0] top_value;
   logic [pcp_pkg::VALUE_W-1:0] compare_value;
   logic                        format_error;

   modport source (output valid, output top_value, output compare_value,
                   output format_error, input ready);
   modport sink   (input valid, input top_value, input compare_value,
                   input format_error, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pcp_char_parser.sv */
// character position counter and digit capture of the command frame
`timescale 1ns / 1ps
`default_nettype none

module pcp_char_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       char_take,
   input  wire logic [pcp_pkg::CHAR_W-1:0] char_code,
   output pcp_pkg::frame_type              frame
);

   logic [pcp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [pcp_pkg::DIGIT_W-1:0] int_ff, int_in;
   logic [pcp_pkg::DIGIT_W-1:0] tenths_ff, tenths_in;
   logic [pcp_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic                        derr_ff, derr_in;

   logic                        skip_char;
   logic                        is_digit;
   logic [pcp_pkg::CHAR_W-1:0]  char_off;
   logic [pcp_pkg::DIGIT_W-1:0] digit;
   logic [pcp_pkg::DUTY_W-1:0]  digit_w;
   logic [pcp_pkg::DUTY_W-1:0]  int_w;

   always_comb begin
      skip_char = (char_code == pcp_pkg::CHAR_LF) || (char_code == pcp_pkg::CHAR_CR);
      is_digit  = (char_code >= pcp_pkg::CHAR_ZERO) && (char_code <= pcp_pkg::CHAR_NINE);
      char_off  = char_code - pcp_pkg::CHAR_ZERO;
      digit     = is_digit ? char_off[pcp_pkg::DIGIT_W-1:0] : '0;
      digit_w   = pcp_pkg::DUTY_W'(digit);
      int_w     = pcp_pkg::DUTY_W'(int_ff);

      frame.last        = !skip_char && (pos_ff == pcp_pkg::POS_LAST);
      frame.digit_error = derr_ff;
      // times ten as two shifts
      frame.freq        = (int_w << 3) + (int_w << 1) + pcp_pkg::FREQ_W'(tenths_ff);
      frame.duty        = duty_ff;

      pos_in    = pos_ff;
      int_in    = int_ff;
      tenths_in = tenths_ff;
      duty_in   = duty_ff;
      derr_in   = derr_ff;

      if (char_take && !skip_char) begin
         if (frame.last) begin
            pos_in    = pcp_pkg::POS_FIRST;
            int_in    = '0;
            tenths_in = '0;
            duty_in   = '0;
            derr_in   = 1'b0;
         end else begin
            pos_in = pos_ff + 4'd1;
            unique case (pos_ff)
               pcp_pkg::POS_INT: begin
                  int_in  = digit;
                  derr_in = derr_ff | !is_digit;
               end
               pcp_pkg::POS_TENTHS: begin
                  tenths_in = digit;
                  derr_in   = derr_ff | !is_digit;
               end
               pcp_pkg::POS_DUTY_TENS: begin
                  duty_in = (digit_w << 3) + (digit_w << 1);
                  derr_in = derr_ff | !is_digit;
               end
               pcp_pkg::POS_DUTY_UNITS: begin
                  duty_in = duty_ff + digit_w;
                  derr_in = derr_ff | !is_digit;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= pcp_pkg::POS_FIRST;
         int_ff    <= '0;
         tenths_ff <= '0;
         duty_ff   <= '0;
         derr_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         int_ff    <= int_in;
         tenths_ff <= tenths_in;
         duty_ff   <= duty_in;
         derr_ff   <= derr_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/pcp_serial_divider.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pcp_serial_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pcp_pkg::div_cmd_type cmd,
   output pcp_pkg::div_status_type  status
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [pcp_pkg::STEP_W-1:0]  cnt_ff;
   logic [pcp_pkg::FREQ_W-1:0]  rem_ff, rem_in;
   logic [pcp_pkg::FREQ_W-1:0]  divisor_ff;
   logic [pcp_pkg::DIV_W-1:0]   work_ff, work_in;

   logic [pcp_pkg::FREQ_W:0]    partial;
   logic [pcp_pkg::FREQ_W:0]    diff;
   logic                        fits;

   always_comb begin
      partial = {rem_ff, work_ff[pcp_pkg::DIV_W-1]};
      diff    = partial - {1'b0, divisor_ff};
      fits    = partial >= {1'b0, divisor_ff};
      // remainder stays below the divisor, so it fits the divisor width
      rem_in  = fits ? diff[pcp_pkg::FREQ_W-1:0] : partial[pcp_pkg::FREQ_W-1:0];
      // dividend bits leave at the top while quotient bits enter at the bottom
      work_in = {work_ff[pcp_pkg::DIV_W-2:0], fits};

      status.busy     = busy_ff;
      status.done     = done_ff;
      status.quotient = work_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff     <= '0;
         work_ff    <= cmd.dividend;
         divisor_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/pwm_command_parser.sv */
// Parser for the serial command "d.d KHz dd %" that yields PWM timer settings.
// req_chan carries one received character per item; line feed and carriage
// return are dropped, every other character moves the frame position on.
// rsp_chan carries one result per twelve counted characters: the timer top
// value, the compare value and a format error flag.
// Characters 1 to 11 of a frame are taken one per cycle. The twelfth starts
// two divisions on one shared serial divider, one quotient bit per cycle:
// 16 steps for the top value and 23 for the compare value. The result is
// written to rsp_chan after both divisions, or without them for a frame with
// a bad digit or zero frequency; req_chan.ready is low meanwhile.
// The result sits in an output register: while the receiver stalls, the next
// frame's characters, the twelfth included, are still taken and its divisions
// run; only its final write into that register waits.
// csr_we writes period_numerator (index 0) or compare_scale (index 1).
// Synchronous reset restores 40000 and 400, clears the frame to position 1
// and empties the output register; req_chan.ready is low during reset.
`timescale 1ns / 1ps
`default_nettype none

module pwm_command_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pcp_req_if.sink                            req_chan,
   pcp_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [pcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pcp_pkg::VALUE_W-1:0]   csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_TOP_WAIT,
      S_CMP_WAIT,
      S_OUT
   } state_type;

   state_type                   state_ff;
   logic [pcp_pkg::VALUE_W-1:0] period_num_ff;
   logic [pcp_pkg::VALUE_W-1:0] compare_scale_ff;

   pcp_pkg::frame_type          frame;
   pcp_pkg::div_cmd_type        div_cmd_ff;
   pcp_pkg::div_status_type     div_stat;

   logic [pcp_pkg::FREQ_W-1:0]  freq_ff;
   logic [pcp_pkg::DIV_W-1:0]   prod_ff;
   logic [pcp_pkg::VALUE_W-1:0] res_top_ff;
   logic [pcp_pkg::VALUE_W-1:0] res_cmp_ff;
   logic                        res_err_ff;

   logic                        rsp_valid_ff;
   logic [pcp_pkg::VALUE_W-1:0] rsp_top_ff;
   logic [pcp_pkg::VALUE_W-1:0] rsp_cmp_ff;
   logic                        rsp_err_ff;

   logic                        char_take;
   logic                        out_load;
   logic [pcp_pkg::VALUE_W-1:0] cmp_sat;

   pcp_char_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .char_take (char_take),
      .char_code (req_chan.char_code),
      .frame     (frame)
   );

   pcp_serial_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd_ff),
      .status (div_stat)
   );

   always_comb begin
      req_chan.ready = (state_ff == S_IDLE) && !reset;
      char_take      = req_chan.valid && req_chan.ready;
      out_load       = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);
      cmp_sat        = (div_stat.quotient[pcp_pkg::DIV_W-1:pcp_pkg::VALUE_W] != '0)
                       ? pcp_pkg::VALUE_MAX : div_stat.quotient[pcp_pkg::VALUE_W-1:0];

      rsp_chan.valid         = rsp_valid_ff;
      rsp_chan.top_value     = rsp_top_ff;
      rsp_chan.compare_value = rsp_cmp_ff;
      rsp_chan.format_error  = rsp_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_num_ff    <= pcp_pkg::PERIOD_NUM_RESET;
         compare_scale_ff <= pcp_pkg::COMPARE_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pcp_pkg::CSR_PERIOD_NUM:    period_num_ff    <= csr_wdata;
            pcp_pkg::CSR_COMPARE_SCALE: compare_scale_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         div_cmd_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         div_cmd_ff.start <= 1'b0;
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (char_take && frame.last) begin
                  freq_ff <= frame.freq;
                  prod_ff <= pcp_pkg::DIV_W'(compare_scale_ff)
                             * pcp_pkg::DIV_W'(frame.duty);
                  if (frame.digit_error || (frame.freq == '0)) begin
                     res_top_ff <= '0;
                     res_cmp_ff <= '0;
                     res_err_ff <= 1'b1;
                     state_ff   <= S_OUT;
                  end else begin
                     res_err_ff          <= 1'b0;
                     div_cmd_ff.start    <= 1'b1;
                     div_cmd_ff.dividend <= {period_num_ff,
                                             (pcp_pkg::DIV_W-pcp_pkg::VALUE_W)'(0)};
                     div_cmd_ff.divisor  <= frame.freq;
                     div_cmd_ff.steps    <= pcp_pkg::STEPS_TOP;
                     state_ff            <= S_TOP_WAIT;
                  end
               end
            end
            S_TOP_WAIT: begin
               if (div_stat.done) begin
                  res_top_ff          <= div_stat.quotient[pcp_pkg::VALUE_W-1:0];
                  div_cmd_ff.start    <= 1'b1;
                  div_cmd_ff.dividend <= prod_ff;
                  div_cmd_ff.divisor  <= freq_ff;
                  div_cmd_ff.steps    <= pcp_pkg::STEPS_COMPARE;
                  state_ff            <= S_CMP_WAIT;
               end
            end
            S_CMP_WAIT: begin
               if (div_stat.done) begin
                  res_cmp_ff <= cmp_sat;
                  state_ff   <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_top_ff <= res_top_ff;
         rsp_cmp_ff <= res_cmp_ff;
         rsp_err_ff <= res_err_ff;
      end
   end

   // the divider is never restarted while a division runs
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_cmd_ff.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a finished division only lands in one of the waiting states
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_TOP_WAIT || state_ff == S_CMP_WAIT))
      else $error("division finished outside a waiting state");

   // a good frame end always launches the top value division
   a_good_frame_divides: assert property (@(posedge clock) disable iff (reset)
      (char_take && frame.last && !frame.digit_error && frame.freq != '0)
      |=> (state_ff == S_TOP_WAIT && div_cmd_ff.start))
      else $error("good frame did not start a division");

   // an error result carries zero settings
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_top_ff == '0 && rsp_cmp_ff == '0))
      else $error("error result with nonzero settings");

endmodule

`default_nettype wire
